>>> rtl/msfc_pkg.sv
// Package for the Mode S frame checker and identification decoder.
// Holds the frame constants, the CRC-24 byte update and the character table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package msfc_pkg;

    typedef logic [3:0] t_count;

    localparam t_count FRAME_BYTES = 4'd14;
    localparam t_count FRAME_LAST  = 4'd13;
    localparam t_count CRC_BYTES   = 4'd11;
    localparam t_count HEAD_BYTES  = 4'd4;

    // Generator 0x1FFF409 without its top bit, which is shifted out.
    localparam logic [23:0] CRC_POLY = 24'hFFF409;

    localparam logic [7:0] CHAR_BLANK = 8'h5F;
    localparam logic [7:0] CHAR_FILL  = 8'h23;
    localparam logic [7:0] CHAR_ALPHA = 8'h40;

    typedef struct packed {
        logic [4:0]  type_code;
        logic        is_ident;
        logic [63:0] callsign;
    } t_ident;

    function automatic logic [23:0] crc_byte(input logic [23:0] crc_in, input logic [7:0] b);
        logic [23:0] c;
        c = crc_in ^ {b, 16'h0000};
        for (int k = 0; k < 8; k++) begin
            if (c[23]) begin
                c = {c[22:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[22:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] glyph(input logic [5:0] code);
        logic [7:0] g;
        if (code >= 6'd1 && code <= 6'd26) begin
            g = CHAR_ALPHA + {2'b00, code};
        end else if (code == 6'd32) begin
            g = CHAR_BLANK;
        end else if (code >= 6'd48 && code <= 6'd57) begin
            g = {2'b00, code};
        end else begin
            g = CHAR_FILL;
        end
        return g;
    endfunction

endpackage

`default_nettype wire

>>> rtl/msfc_if.sv
// Handshake channels of the Mode S frame checker: the byte stream in and
// the decoded frame result out. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface msfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source(output valid, output data_byte, output frame_start, input ready);
    modport sink(input valid, input data_byte, input frame_start, output ready);
endinterface

interface msfc_result_if;
    logic        valid;
    logic        ready;
    logic        crc_ok;
    logic [23:0] computed_parity;
    logic [4:0]  downlink_format;
    logic [23:0] aircraft_address;
    logic [4:0]  type_code;
    logic        is_identification;
    logic [63:0] callsign_ascii;

    modport source(output valid, output crc_ok, output computed_parity,
                   output downlink_format, output aircraft_address, output type_code,
                   output is_identification, output callsign_ascii, input ready);
    modport sink(input valid, input crc_ok, input computed_parity,
                 input downlink_format, input aircraft_address, input type_code,
                 input is_identification, input callsign_ascii, output ready);
endinterface

`default_nettype wire

>>> rtl/mode_s_frame_check_and_ident_decode.sv
// Mode S extended squitter checker: takes one frame byte per transfer, runs the
// CRC-24 over bytes 0 to 10 and gives one result per 14-byte frame. The input
// takes a byte in every cycle; the result sits in an output register, and the
// input stalls only when that register is still full, the receiver is not ready
// and thirteen bytes of the current frame are already in. A result is registered
// in the cycle after its last byte is taken. Depends on msfc_pkg, msfc_if and msfc_ident.
`timescale 1ns / 1ps
`default_nettype none

module mode_s_frame_check_and_ident_decode (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    msfc_byte_if.sink       i_byte,
    msfc_result_if.source   o_result
);
    import msfc_pkg::*;

    t_count      r_count, n_count;
    logic [23:0] r_crc, n_crc;
    logic [15:0] r_parity, n_parity;
    logic [31:0] r_head, n_head;
    logic [55:0] r_me, n_me;

    logic        r_out_valid;
    logic        r_crc_ok;
    logic [23:0] r_computed;
    logic [4:0]  r_df;
    logic [23:0] r_icao;
    t_ident      r_ident;

    t_ident      ident;
    t_count      pos;
    logic        in_xfer;
    logic        take;
    logic        done;
    logic [23:0] crc_base;
    logic [7:0]  b;

    msfc_ident u_ident (
        .i_me    (r_me),
        .o_ident (ident)
    );

    assign i_byte.ready = !r_out_valid || o_result.ready || (r_count != FRAME_LAST);
    assign in_xfer      = i_byte.valid && i_byte.ready;
    assign b            = i_byte.data_byte;
    assign pos          = i_byte.frame_start ? '0 : r_count;
    assign take         = in_xfer && (pos < FRAME_BYTES);
    assign done         = take && (pos == FRAME_LAST);
    assign crc_base     = i_byte.frame_start ? 24'h0 : r_crc;

    always_comb begin
        n_count  = r_count;
        n_crc    = r_crc;
        n_parity = r_parity;
        n_head   = r_head;
        n_me     = r_me;
        if (take) begin
            n_count = pos + 4'd1;
            n_crc   = (pos < CRC_BYTES) ? crc_byte(crc_base, b) : crc_base;
            if (pos < HEAD_BYTES) begin
                n_head = {r_head[23:0], b};
            end else if (pos < CRC_BYTES) begin
                n_me = {r_me[47:0], b};
            end else begin
                n_parity = {r_parity[7:0], b};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_crc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_crc   <= n_crc;
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_parity <= n_parity;
        r_head   <= n_head;
        r_me     <= n_me;
        if (done) begin
            r_crc_ok   <= (r_crc == {r_parity, b});
            r_computed <= r_crc;
            r_df       <= r_head[31:27];
            r_icao     <= r_head[23:0];
            r_ident    <= ident;
        end
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.crc_ok            = r_crc_ok;
    assign o_result.computed_parity   = r_computed;
    assign o_result.downlink_format   = r_df;
    assign o_result.aircraft_address  = r_icao;
    assign o_result.type_code         = r_ident.type_code;
    assign o_result.is_identification = r_ident.is_ident;
    assign o_result.callsign_ascii    = r_ident.callsign;

endmodule

`default_nettype wire

>>> rtl/msfc_ident.sv
// Decodes the ME field: type code, identification flag and callsign in ASCII.
// Depends on msfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msfc_ident (
    input  wire logic [55:0]    i_me,
    output msfc_pkg::t_ident    o_ident
);
    import msfc_pkg::*;

    logic [4:0] type_code;
    logic       is_ident;
    logic [7:0] chars [8];
    logic [7:0] outc  [8];
    logic [8:0] trail;

    assign type_code = i_me[55:51];
    assign is_ident  = (type_code >= 5'd1) && (type_code <= 5'd4);

    always_comb begin
        trail[8] = 1'b1;
        for (int k = 7; k >= 0; k--) begin
            chars[k] = glyph(i_me[42 - 6 * k +: 6]);
            trail[k] = trail[k + 1] && (chars[k] == CHAR_BLANK);
            outc[k]  = trail[k] ? 8'h00 : chars[k];
        end
    end

    assign o_ident.type_code = type_code;
    assign o_ident.is_ident  = is_ident;
    assign o_ident.callsign  = is_ident ? {outc[0], outc[1], outc[2], outc[3],
                                           outc[4], outc[5], outc[6], outc[7]} : 64'h0;

endmodule

`default_nettype wire

>>> rtl/msfc_checker.sv
// Port-level checks for the Mode S frame checker, bound to its top level.
// Depends on mode_s_frame_check_and_ident_decode and the channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module msfc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [23:0] i_computed_parity,
    input wire logic [23:0] i_aircraft_address,
    input wire logic [4:0]  i_type_code,
    input wire logic        i_is_identification,
    input wire logic [63:0] i_callsign_ascii
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Result dropped before its transfer.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_computed_parity) && $stable(i_aircraft_address)
            && $stable(i_callsign_ascii))
        else $error("Result changed while stalled.");

    a_ident_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_is_identification == ((i_type_code >= 5'd1) && (i_type_code <= 5'd4))))
        else $error("Identification flag disagrees with the type code.");

    a_callsign_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_is_identification |-> (i_callsign_ascii == 64'h0))
        else $error("Callsign is not zero for a non-identification frame.");

    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready))
        else $error("Result appeared without a byte transfer.");

endmodule

bind mode_s_frame_check_and_ident_decode msfc_checker u_msfc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_byte.valid),
    .i_in_ready          (i_byte.ready),
    .i_out_valid         (o_result.valid),
    .i_out_ready         (o_result.ready),
    .i_computed_parity   (o_result.computed_parity),
    .i_aircraft_address  (o_result.aircraft_address),
    .i_type_code         (o_result.type_code),
    .i_is_identification (o_result.is_identification),
    .i_callsign_ascii    (o_result.callsign_ascii)
);

`default_nettype wire
